// ===== src/lpsc_pkg.sv =====
`timescale 1ns / 1ps

package lpsc_pkg;

    localparam int SIZE_W      = 24;
    localparam int ACC_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int SC_LEN      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_FIELD_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY    = 2'd1;

    localparam logic [2:0]        LFB_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] CAP_RESET = {SIZE_W{1'b1}};

    typedef enum logic [3:0] {
        PH_EXPECT  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DROP    = 4'b1000
    } t_phase;

    // one queued command: a start code, a payload word and/or an end marker
    typedef struct packed {
        logic              emit_sc;
        logic              emit_data;
        logic [7:0]        data;
        logic              emit_end;
        logic              corrupt;
        logic [SIZE_W-1:0] size;
    } t_cmd;

    function automatic logic [2:0] eff_len_bytes(input logic [2:0] v);
        logic [2:0] r;
        case (v)
            3'd1:    r = 3'd1;
            3'd2:    r = 3'd2;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic t_phase finish_length(input logic [ACC_W-1:0]  acc,
                                             input logic [SIZE_W-1:0] unit_rem,
                                             input logic [SIZE_W-1:0] out_rem);
        t_phase ph;
        if (acc > ACC_W'(unit_rem) || acc > ACC_W'(out_rem)) begin
            ph = PH_DROP;
        end else if (acc == '0) begin
            ph = PH_EXPECT;
        end else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

endpackage

// ===== src/length_prefixed_to_start_code.sv =====
`timescale 1ns / 1ps
// an accepted word is parsed and its command pushed into the command queue; the emitter
// moves the queue head into the output register, which holds its word while stalled
// throughput: one input word per cycle while the queue is not full; a payload word gives one
// output word and the first word of each length field four start code words, one per cycle
// while not stalled; a four-entry command queue between parser and emitter absorbs the bursts
// reset: synchronous active low; clears parser state and queue, config to its reset values

module length_prefixed_to_start_code import lpsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_first_of_unit,
    input  logic [SIZE_W-1:0]    i_unit_size,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_end_of_unit,
    output logic                 o_corrupt,
    output logic [SIZE_W-1:0]    o_converted_size
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd cmd;
    t_cmd head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    lpsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_q_full        (q_full),
        .i_in_byte       (i_in_byte),
        .i_first_of_unit (i_first_of_unit),
        .i_unit_size     (i_unit_size),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    lpsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    lpsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_head           (head),
        .i_out_stall      (i_out_stall),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_unit    (o_end_of_unit),
        .o_corrupt        (o_corrupt),
        .o_converted_size (o_converted_size)
    );

endmodule

// ===== src/lpsc_front.sv =====
`timescale 1ns / 1ps

module lpsc_front import lpsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_q_full,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_first_of_unit,
    input  logic [SIZE_W-1:0]     i_unit_size,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [2:0]        r_lfb;
    logic [SIZE_W-1:0] r_cap;
    t_phase            r_ph,   n_ph;
    logic [2:0]        r_seen, n_seen;
    logic [ACC_W-1:0]  r_acc,  n_acc;
    logic [SIZE_W-1:0] r_ur,   n_ur;
    logic [ACC_W-1:0]  r_pr,   n_pr;
    logic [SIZE_W-1:0] r_orem, n_orem;
    logic [SIZE_W-1:0] r_ow,   n_ow;
    logic [2:0]        r_cl,   n_cl;
    logic              accept;

    assign accept = i_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfb <= LFB_RESET;
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEN_FIELD_BYTES: r_lfb <= i_cfg_data[2:0];
                CFG_OUT_CAPACITY:    r_cap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ph   = r_ph;
        n_seen = r_seen;
        n_acc  = r_acc;
        n_ur   = r_ur;
        n_pr   = r_pr;
        n_orem = r_orem;
        n_ow   = r_ow;
        n_cl   = r_cl;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            if (i_first_of_unit) begin
                n_ur   = i_unit_size;
                n_orem = r_cap;
                n_ow   = '0;
                n_cl   = eff_len_bytes(r_lfb);
                n_ph   = PH_EXPECT;
                n_seen = '0;
                n_acc  = '0;
                n_pr   = '0;
            end
            if (i_first_of_unit && i_unit_size == '0) begin
                // empty access unit: end marker only
                o_push       = 1'b1;
                o_cmd.emit_end = 1'b1;
            end else if (n_ur != '0) begin
                case (n_ph)
                    PH_EXPECT: begin
                        if (n_ur < SIZE_W'(n_cl) || n_orem < SIZE_W'(SC_LEN)) begin
                            n_ph = PH_DROP;
                        end else begin
                            o_cmd.emit_sc = 1'b1;
                            n_orem = n_orem - SIZE_W'(SC_LEN);
                            n_ow   = n_ow + SIZE_W'(SC_LEN);
                            n_acc  = ACC_W'(i_in_byte);
                            n_seen = 3'd1;
                            if (n_seen >= n_cl) begin
                                n_pr = n_acc;
                                n_ph = finish_length(n_acc, n_ur - 1'b1, n_orem);
                            end else begin
                                n_ph = PH_LENGTH;
                            end
                        end
                    end
                    PH_LENGTH: begin
                        n_acc  = {n_acc[ACC_W-9:0], i_in_byte};
                        n_seen = n_seen + 3'd1;
                        if (n_seen >= n_cl) begin
                            n_pr = n_acc;
                            n_ph = finish_length(n_acc, n_ur - 1'b1, n_orem);
                        end
                    end
                    PH_PAYLOAD: begin
                        o_cmd.emit_data = 1'b1;
                        o_cmd.data      = i_in_byte;
                        n_orem = n_orem - 1'b1;
                        n_ow   = n_ow + 1'b1;
                        n_pr   = n_pr - 1'b1;
                        if (n_pr == '0) begin
                            n_ph = PH_EXPECT;
                        end
                    end
                    default: ;
                endcase
                n_ur = n_ur - 1'b1;
                if (n_ur == '0) begin
                    o_cmd.emit_end = 1'b1;
                    o_cmd.corrupt  = (n_ph != PH_EXPECT);
                    o_cmd.size     = n_ow;
                    n_ph   = PH_EXPECT;
                    n_seen = '0;
                    n_acc  = '0;
                    n_pr   = '0;
                end
                o_push = o_cmd.emit_sc || o_cmd.emit_data || o_cmd.emit_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_EXPECT;
            r_seen <= '0;
            r_acc  <= '0;
            r_ur   <= '0;
            r_pr   <= '0;
            r_orem <= '0;
            r_ow   <= '0;
            r_cl   <= LFB_RESET;
        end else begin
            r_ph   <= n_ph;
            r_seen <= n_seen;
            r_acc  <= n_acc;
            r_ur   <= n_ur;
            r_pr   <= n_pr;
            r_orem <= n_orem;
            r_ow   <= n_ow;
            r_cl   <= n_cl;
        end
    end

endmodule

// ===== src/lpsc_queue.sv =====
`timescale 1ns / 1ps

module lpsc_queue import lpsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/lpsc_back.sv =====
`timescale 1ns / 1ps

module lpsc_back import lpsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_cmd              i_head,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_end_of_unit,
    output logic              o_corrupt,
    output logic [SIZE_W-1:0] o_converted_size
);

    logic              r_ov;
    logic [7:0]        r_byte;
    logic              r_bv;
    logic              r_eou;
    logic              r_bad;
    logic [SIZE_W-1:0] r_size;
    logic [1:0]        r_sc_idx, n_sc_idx;
    logic              r_sc_done, n_sc_done;
    logic              r_data_done, n_data_done;

    logic              can_load;
    logic              p_sc;
    logic              p_data;
    logic              p_end;
    logic              emit;
    logic [7:0]        e_byte;
    logic              e_bv;
    logic              e_eou;
    logic              e_bad;
    logic [SIZE_W-1:0] e_size;

    assign can_load = !r_ov || !i_out_stall;
    assign p_sc     = !i_empty && i_head.emit_sc && !r_sc_done;
    assign p_data   = !i_empty && i_head.emit_data && !r_data_done;
    assign p_end    = !i_empty && i_head.emit_end;

    // pick the next word of the head command; pop on its last word
    always_comb begin
        emit        = 1'b0;
        o_pop       = 1'b0;
        e_byte      = '0;
        e_bv        = 1'b0;
        e_eou       = 1'b0;
        e_bad       = 1'b0;
        e_size      = '0;
        n_sc_idx    = r_sc_idx;
        n_sc_done   = r_sc_done;
        n_data_done = r_data_done;
        if (can_load) begin
            if (p_sc) begin
                emit     = 1'b1;
                e_bv     = 1'b1;
                e_byte   = (r_sc_idx == 2'd3) ? 8'h01 : 8'h00;
                n_sc_idx = r_sc_idx + 2'd1;
                if (r_sc_idx == 2'd3) begin
                    n_sc_done = 1'b1;
                    o_pop     = !p_data && !p_end;
                end
            end else if (p_data) begin
                emit        = 1'b1;
                e_bv        = 1'b1;
                e_byte      = i_head.data;
                n_data_done = 1'b1;
                o_pop       = !p_end;
            end else if (p_end) begin
                emit   = 1'b1;
                e_eou  = 1'b1;
                e_bad  = i_head.corrupt;
                e_size = i_head.size;
                o_pop  = 1'b1;
            end
            if (o_pop) begin
                n_sc_idx    = '0;
                n_sc_done   = 1'b0;
                n_data_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov        <= 1'b0;
            r_sc_idx    <= '0;
            r_sc_done   <= 1'b0;
            r_data_done <= 1'b0;
        end else begin
            r_sc_idx    <= n_sc_idx;
            r_sc_done   <= n_sc_done;
            r_data_done <= n_data_done;
            if (can_load) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && emit) begin
            r_byte <= e_byte;
            r_bv   <= e_bv;
            r_eou  <= e_eou;
            r_bad  <= e_bad;
            r_size <= e_size;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_byte       = r_byte;
    assign o_byte_valid     = r_bv;
    assign o_end_of_unit    = r_eou;
    assign o_corrupt        = r_bad;
    assign o_converted_size = r_size;

endmodule

// ===== dv/tb_length_prefixed_to_start_code.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_to_start_code;
    import lpsc_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int N_PHASES      = 7;
    localparam int N_DIR         = 35;

    // one output word of the converter
    typedef struct packed {
        logic [7:0]        data;
        logic              vld;
        logic              eou;
        logic              bad;
        logic [SIZE_W-1:0] size;
    } t_out_word;

    // how a directed row gets its expected words
    typedef enum logic [2:0] {
        L_PRED,
        L_NONE,
        L_SC,
        L_END_OK0,
        L_END_BAD0
    } t_lit;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    val;
        logic [7:0]           b;
        logic                 first;
        t_lit                 lit;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [7:0]           i_in_byte = '0;
    logic                 i_first_of_unit = 1'b0;
    logic [SIZE_W-1:0]    i_unit_size = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_byte_valid;
    logic                 o_end_of_unit;
    logic                 o_corrupt;
    logic [SIZE_W-1:0]    o_converted_size;

    length_prefixed_to_start_code dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_first_of_unit  (i_first_of_unit),
        .i_unit_size      (i_unit_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_unit    (o_end_of_unit),
        .o_corrupt        (o_corrupt),
        .o_converted_size (o_converted_size)
    );

    always #5 i_clk = ~i_clk;

    // converter model state
    logic [2:0]        cfg_len_bytes = LFB_RESET;
    logic [SIZE_W-1:0] cfg_out_cap = CAP_RESET;
    logic [2:0]        cur_len_bytes = 3'd4;
    t_phase            parse_ph = PH_EXPECT;
    logic [2:0]        len_seen = '0;
    logic [ACC_W-1:0]  len_acc = '0;
    logic [SIZE_W-1:0] unit_left = '0;
    logic [ACC_W-1:0]  payload_left = '0;
    logic [SIZE_W-1:0] out_left = '0;
    logic [SIZE_W-1:0] out_count = '0;

    t_out_word step_words [$];
    t_out_word conv_q [$];
    int        mismatches = 0;
    int        snd_pct = 6;
    int        rcv_pct = 46;

    t_dir_row dir_tbl [0:N_DIR-1] = '{
        '{1'b0, '0, 24'd0,      8'h5A, 1'b1, L_END_OK0},  // empty access unit
        '{1'b0, '0, 24'hFFFFFF, 8'hFF, 1'b0, L_NONE},     // stray word, no unit open
        '{1'b0, '0, 24'd3,      8'h00, 1'b1, L_NONE},     // too short for a 4-byte length
        '{1'b0, '0, 24'h000000, 8'h00, 1'b0, L_NONE},
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_END_BAD0},
        '{1'b0, '0, 24'd5,      8'h00, 1'b1, L_SC},       // good unit, one payload word
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h01, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'hFF, 1'b0, L_PRED},
        '{1'b0, '0, 24'hFFFFFF, 8'h00, 1'b1, L_SC},       // huge unit, abandoned next
        '{1'b0, '0, 24'd5,      8'h00, 1'b1, L_SC},
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'hFF, 1'b0, L_PRED},     // length beyond the unit
        '{1'b0, '0, 24'd0,      8'hAA, 1'b0, L_PRED},
        '{1'b1, CFG_LEN_FIELD_BYTES, 24'd1, 8'h00, 1'b0, L_PRED},
        '{1'b1, CFG_OUT_CAPACITY,    24'd3, 8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd2,      8'h01, 1'b1, L_NONE},     // no room for a start code
        '{1'b0, '0, 24'd0,      8'h7E, 1'b0, L_END_BAD0},
        '{1'b1, CFG_LEN_FIELD_BYTES, 24'd2,  8'h00, 1'b0, L_PRED},
        '{1'b1, CFG_OUT_CAPACITY,    24'd10, 8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd3,      8'h00, 1'b1, L_SC},       // zero length, then cut length
        '{1'b0, '0, 24'd0,      8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h33, 1'b0, L_PRED},
        '{1'b1, CFG_LEN_FIELD_BYTES, 24'd1, 8'h00, 1'b0, L_PRED},
        '{1'b1, CFG_OUT_CAPACITY,    24'd5, 8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd4,      8'h02, 1'b1, L_SC},       // payload beyond output room
        '{1'b0, '0, 24'd0,      8'h11, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h22, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h33, 1'b0, L_PRED},
        '{1'b1, CFG_OUT_CAPACITY, 24'hFFFFFF, 8'h00, 1'b0, L_PRED},
        '{1'b0, '0, 24'd3,      8'h00, 1'b1, L_SC},
        '{1'b0, '0, 24'd0,      8'h01, 1'b0, L_PRED},
        '{1'b0, '0, 24'd0,      8'h80, 1'b0, L_PRED}
    };

    task automatic emit_byte(input logic [7:0] b);
        step_words.push_back('{data: b, vld: 1'b1, eou: 1'b0, bad: 1'b0, size: '0});
        out_left  = out_left - 1'b1;
        out_count = out_count + 1'b1;
    endtask

    task automatic close_length();
        payload_left = len_acc;
        if (len_acc > ACC_W'(unit_left) || len_acc > ACC_W'(out_left)) begin
            parse_ph = PH_DROP;
        end else if (len_acc == '0) begin
            parse_ph = PH_EXPECT;
        end else begin
            parse_ph = PH_PAYLOAD;
        end
    endtask

    // words the converter owes for one accepted input word
    task automatic convert_byte(input logic [7:0] b, input logic f,
                                input logic [SIZE_W-1:0] us, output bit taken);
        logic [SIZE_W-1:0] left_before;
        step_words.delete();
        taken = 1'b1;
        if (f) begin
            unit_left     = us;
            out_left      = cfg_out_cap;
            out_count     = '0;
            cur_len_bytes = (cfg_len_bytes == 3'd1) ? 3'd1 :
                            (cfg_len_bytes == 3'd2) ? 3'd2 : 3'd4;
            parse_ph      = PH_EXPECT;
            len_seen      = '0;
            len_acc       = '0;
            payload_left  = '0;
            if (us == '0) begin
                step_words.push_back('{data: '0, vld: 1'b0, eou: 1'b1, bad: 1'b0, size: '0});
                return;
            end
        end else if (unit_left == '0) begin
            taken = 1'b0;
            return;
        end
        left_before = unit_left;
        unit_left   = unit_left - 1'b1;
        case (parse_ph)
            PH_EXPECT: begin
                if (left_before < SIZE_W'(cur_len_bytes) || out_left < SIZE_W'(SC_LEN)) begin
                    parse_ph = PH_DROP;
                end else begin
                    emit_byte(8'h00);
                    emit_byte(8'h00);
                    emit_byte(8'h00);
                    emit_byte(8'h01);
                    len_acc  = ACC_W'(b);
                    len_seen = 3'd1;
                    if (len_seen >= cur_len_bytes) close_length();
                    else parse_ph = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                len_acc  = {len_acc[ACC_W-9:0], b};
                len_seen = len_seen + 1'b1;
                if (len_seen >= cur_len_bytes) close_length();
            end
            PH_PAYLOAD: begin
                emit_byte(b);
                payload_left = payload_left - 1'b1;
                if (payload_left == '0) parse_ph = PH_EXPECT;
            end
            default: ;
        endcase
        if (unit_left == '0) begin
            step_words.push_back('{data: '0, vld: 1'b0, eou: 1'b1,
                                   bad: (parse_ph != PH_EXPECT), size: out_count});
            parse_ph     = PH_EXPECT;
            len_seen     = '0;
            len_acc      = '0;
            payload_left = '0;
        end
    endtask

    // called right after an accepting edge, or with i_in_valid already low
    task automatic send_item(input logic [7:0] b, input logic f, input logic [SIZE_W-1:0] us,
                             input t_lit lit, output bit taken);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < snd_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_first_of_unit <= f;
        i_unit_size     <= us;
        do @(posedge i_clk); while (o_in_stall);
        convert_byte(b, f, us, taken);
        case (lit)
            L_PRED: foreach (step_words[k]) conv_q.push_back(step_words[k]);
            L_SC: begin
                conv_q.push_back('{data: 8'h00, vld: 1'b1, eou: 1'b0, bad: 1'b0, size: '0});
                conv_q.push_back('{data: 8'h00, vld: 1'b1, eou: 1'b0, bad: 1'b0, size: '0});
                conv_q.push_back('{data: 8'h00, vld: 1'b1, eou: 1'b0, bad: 1'b0, size: '0});
                conv_q.push_back('{data: 8'h01, vld: 1'b1, eou: 1'b0, bad: 1'b0, size: '0});
            end
            L_END_OK0:
                conv_q.push_back('{data: 8'h00, vld: 1'b0, eou: 1'b1, bad: 1'b0, size: '0});
            L_END_BAD0:
                conv_q.push_back('{data: 8'h00, vld: 1'b0, eou: 1'b1, bad: 1'b1, size: '0});
            default: ;
        endcase
    endtask

    // sender holds off until the converter has drained
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (conv_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LEN_FIELD_BYTES) cfg_len_bytes = data[2:0];
        else if (idx == CFG_OUT_CAPACITY) cfg_out_cap = data;
    endtask

    task automatic send_access_unit(inout int counted);
        logic [7:0]        ub [$];
        logic [ACC_W-1:0]  len_val;
        logic [SIZE_W-1:0] usz;
        int                eff, kind, nnal, plen, nsend;
        bit                taken;
        eff  = (cfg_len_bytes == 3'd1) ? 1 : (cfg_len_bytes == 3'd2) ? 2 : 4;
        kind = $urandom_range(99, 0);
        if (kind >= 90 && kind < 94) begin
            send_item(8'($urandom()), 1'b1, '0, L_PRED, taken);
            counted += taken;
            return;
        end
        nnal = $urandom_range(3, 1);
        for (int j = 0; j < nnal; j++) begin
            plen    = $urandom_range(12, 0);
            len_val = ($urandom_range(19, 0) == 0) ? ACC_W'($urandom()) : ACC_W'(plen);
            for (int k = eff - 1; k >= 0; k--) ub.push_back(8'(len_val >> (8 * k)));
            repeat (plen) ub.push_back(8'($urandom()));
        end
        // garbage content in a correctly sized unit
        if (kind >= 94) foreach (ub[k]) ub[k] = 8'($urandom());
        nsend = ub.size();
        usz   = SIZE_W'(nsend);
        if (kind >= 72 && kind < 80) begin
            nsend = $urandom_range(ub.size(), 1);
            usz   = SIZE_W'(nsend);
        end else if (kind >= 80 && kind < 86) begin
            // random size: usually left open and abandoned by the next unit
            usz   = SIZE_W'($urandom());
            nsend = $urandom_range(ub.size(), 1);
        end
        for (int k = 0; k < nsend; k++) begin
            send_item(ub[k], k == 0, (k == 0) ? usz : SIZE_W'($urandom()), L_PRED, taken);
            counted += taken;
        end
        if (kind >= 86 && kind < 90) begin
            repeat ($urandom_range(3, 1)) begin
                send_item(8'($urandom()), 1'b0, SIZE_W'($urandom()), L_PRED, taken);
                counted += taken;
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < rcv_pct);
    end

    always @(posedge i_clk) begin : out_check
        t_out_word got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{data: o_out_byte, vld: o_byte_valid, eou: o_end_of_unit,
                    bad: o_corrupt, size: o_converted_size};
            if (conv_q.size() == 0) begin
                $display("%0t: unexpected word: byte %h valid %b end %b corrupt %b size %0d",
                         $time, got.data, got.vld, got.eou, got.bad, got.size);
                mismatches++;
            end else begin
                want = conv_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected byte %h valid %b end %b corrupt %b size %0d",
                             $time, want.data, want.vld, want.eou, want.bad, want.size);
                    $display("%0t:           actual byte %h valid %b end %b corrupt %b size %0d",
                             $time, got.data, got.vld, got.eou, got.bad, got.size);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [2:0]        lfb_plan [0:N_PHASES-1] = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd5};
        logic [SIZE_W-1:0] cap;
        logic [31:0]       upper;
        int                rand_total, phase_cnt;
        bit                taken;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].is_cfg) begin
                write_reg(dir_tbl[i].idx, dir_tbl[i].val);
            end else begin
                send_item(dir_tbl[i].b, dir_tbl[i].first, dir_tbl[i].val, dir_tbl[i].lit,
                          taken);
            end
        end

        rand_total = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1:       cap = SIZE_W'($urandom_range(60, 20));
                2:       cap = '0;
                3:       cap = SIZE_W'($urandom());
                4:       cap = SIZE_W'($urandom_range(30, 4));
                5:       cap = SIZE_W'(3);
                default: cap = '1;
            endcase
            upper = $urandom();
            // upper data bits of the length register write are don't-care
            write_reg(CFG_LEN_FIELD_BYTES, {upper[SIZE_W-4:0], lfb_plan[p]});
            write_reg(CFG_OUT_CAPACITY, cap);
            phase_cnt = 0;
            while (phase_cnt < PHASE_ITEMS) begin
                if (rand_total < 117) begin
                    snd_pct = 6;
                    rcv_pct = 46;
                end else if (rand_total < 234) begin
                    snd_pct = 46;
                    rcv_pct = 6;
                end else begin
                    snd_pct = 0;
                    rcv_pct = 0;
                end
                rand_total -= phase_cnt;
                send_access_unit(phase_cnt);
                rand_total += phase_cnt;
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
